@@ design/pgu_pkg.sv @@
// Shared types, constants and a helper function for the pixel grid upscaler.
`default_nettype none
package pgu_pkg;

	localparam int LINE_PIXELS = 32;
	localparam int STRETCH_MAX = 16;

	localparam int COL_W     = 5;
	localparam int ROW_W     = 4;
	localparam int CH_W      = 8;
	localparam int COLOUR_W  = 3 * CH_W;
	localparam int PAT_W     = 2;
	localparam int STRETCH_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 5;

	localparam int LINE_AW = $clog2(LINE_PIXELS);
	// pixel index within a span, 0 .. STRETCH_MAX-1
	localparam int KW      = $clog2(STRETCH_MAX);

	// floor(x/3) as (x*43)>>7, exact for x below 128
	localparam int RECIP_MUL = 43;
	localparam int RECIP_SH  = 7;
	localparam int RECIP_W   = $clog2(RECIP_MUL + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_EMIT = 1'b1
	} mode_t;

	typedef enum logic [PAT_W-1:0] {
		PAT_PLAIN  = 2'd0,
		PAT_GRID   = 2'd1,
		PAT_SUBPIX = 2'd2
	} pattern_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN = 1'b0,
		CFG_STRETCH = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] colour;
		logic                row0;
	} pgu_cmd_t;

	// span geometry: last pixel index and the two stripe splits
	typedef struct packed {
		logic [KW-1:0] sm1;
		logic [KW-1:0] s1;
		logic [KW-1:0] s2;
	} pgu_geom_t;

	function automatic pgu_geom_t pgu_geometry(input logic [STRETCH_W-1:0] raw);
		pgu_geom_t                g;
		logic [KW-1:0]            m1;
		logic [KW+RECIP_W-1:0]    prod;
		logic [KW-1:0]            q;
		if (int'(raw) < 2) begin
			m1 = KW'(1);
		end else if (int'(raw) > STRETCH_MAX) begin
			m1 = KW'(STRETCH_MAX - 1);
		end else begin
			m1 = KW'(raw - STRETCH_W'(1));
		end
		prod  = (KW+RECIP_W)'(m1) * (KW+RECIP_W)'(RECIP_MUL);
		q     = KW'(prod >> RECIP_SH);
		g.sm1 = m1;
		g.s1  = q + KW'(1);
		g.s2  = KW'({q, 1'b1});
		return g;
	endfunction

endpackage
`default_nettype wire

@@ design/pgu_if.sv @@
// Handshake interfaces for source items and output pixels.
`default_nettype none
interface pgu_in_if
	import pgu_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [COL_W-1:0]  column;
	logic [ROW_W-1:0]  sub_row;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;

	modport source (output valid, mode, column, sub_row, red, green, blue, input ready);
	modport sink   (input valid, mode, column, sub_row, red, green, blue, output ready);
endinterface

interface pgu_out_if
	import pgu_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  out_red;
	logic [CH_W-1:0]  out_green;
	logic [CH_W-1:0]  out_blue;
	logic             last_of_run;

	modport source (output valid, out_red, out_green, out_blue, last_of_run, input ready);
	modport sink   (input valid, out_red, out_green, out_blue, last_of_run, output ready);
endinterface
`default_nettype wire

@@ design/pixel_grid_upscaler_top.sv @@
// Top level of the pixel grid upscaler: configuration registers and the three stages.
//
//  channel   dir  handshake      payload
//  item      in   valid/ready    mode, column, sub_row, red, green, blue
//  result    out  valid/ready    out_red, out_green, out_blue, last_of_run
//  cfg       in   cfg_we         cfg_index, cfg_data
//
//  A load item gives no pixels; an emit item gives stretch pixels, one per cycle while result.ready holds,
//  from the back-end span counter, spans following each other without gaps.
//  The first pixel of an emit is valid once the item has passed the front read register,
//  the queue entry, the span start and the output register.
//  Reset clears control only; the line store holds junk until each column is loaded.
//  A stalled output fills the two-entry queue, then the front end drops item.ready.
`default_nettype none
module pixel_grid_upscaler_top
	import pgu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	pgu_in_if.sink                     item,
	pgu_out_if.source                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	pattern_t   pattern_q;
	pgu_geom_t  geom_q;
	pgu_cmd_t   f_cmd;
	pgu_cmd_t   q_cmd;
	logic       f_push;
	logic       q_full;
	logic       q_pop;
	logic       q_avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_SUBPIX;
			geom_q    <= pgu_geometry(STRETCH_W'(10));
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PATTERN: pattern_q <= pattern_t'(cfg_data[PAT_W-1:0]);
				CFG_STRETCH: geom_q    <= pgu_geometry(cfg_data[STRETCH_W-1:0]);
				default:     pattern_q <= pattern_q;
			endcase
		end
	end

	pgu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (f_cmd),
		.cmd_valid (f_push),
		.cmd_full  (q_full)
	);

	pgu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data (f_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_cmd),
		.not_empty (q_avail)
	);

	pgu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pattern   (pattern_q),
		.geom      (geom_q),
		.cmd       (q_cmd),
		.cmd_avail (q_avail),
		.cmd_pop   (q_pop),
		.result    (result)
	);

endmodule
`default_nettype wire

@@ design/pgu_front.sv @@
// Front end: takes items, writes loads into the line store, reads colour for emits.
`default_nettype none
module pgu_front
	import pgu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	pgu_in_if.sink     item,
	output pgu_cmd_t   cmd,
	output logic       cmd_valid,
	input  wire logic  cmd_full
);

	logic [COLOUR_W-1:0] line_mem [LINE_PIXELS];
	logic [COLOUR_W-1:0] rdata_q;
	logic                valid_s1;
	logic                row0_s1;
	logic                acc;
	logic                push;

	assign push       = valid_s1 && !cmd_full;
	assign item.ready = !valid_s1 || !cmd_full;
	assign acc        = item.valid && item.ready;

	always_ff @(posedge clk) begin
		if (acc) begin
			if (mode_t'(item.mode) == MODE_LOAD) begin
				line_mem[item.column[LINE_AW-1:0]] <= {item.red, item.green, item.blue};
			end else begin
				rdata_q <= line_mem[item.column[LINE_AW-1:0]];
				row0_s1 <= (item.sub_row == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc && mode_t'(item.mode) == MODE_EMIT) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	assign cmd_valid  = push;
	assign cmd.colour = rdata_q;
	assign cmd.row0   = row0_s1;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cmd_full |=> valid_s1)
		else $error("front stage dropped a stalled emit");
	a_no_acc_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cmd_full |-> !acc)
		else $error("item taken while front stage stalled");

endmodule
`default_nettype wire

@@ design/pgu_queue.sv @@
// Short command queue between the front and back ends.
`default_nettype none
module pgu_queue
	import pgu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pgu_cmd_t  push_data,
	output logic           full,
	input  wire logic      pop,
	output pgu_cmd_t       pop_data,
	output logic           not_empty
);

	pgu_cmd_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	assign full      = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ design/pgu_back.sv @@
// Back end: expands each emit command into a span of output pixels.
`default_nettype none
module pgu_back
	import pgu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire pattern_t   pattern,
	input  wire pgu_geom_t  geom,
	input  wire pgu_cmd_t   cmd,
	input  wire logic       cmd_avail,
	output logic            cmd_pop,
	pgu_out_if.source       result
);

	logic                busy_q;
	logic [KW-1:0]       k_q;
	logic [COLOUR_W-1:0] colour_q;
	logic                row0_q;
	logic                out_valid_q;
	logic [CH_W-1:0]     red_q, green_q, blue_q;
	logic                last_q;
	logic                advance;
	logic                at_last;
	logic [CH_W-1:0]     pr, pg, pb;
	logic                black;

	assign advance = busy_q && (!out_valid_q || result.ready);
	assign at_last = (k_q == geom.sm1);
	assign cmd_pop = cmd_avail && (!busy_q || (advance && at_last));
	assign black   = row0_q || (k_q == '0);

	always_comb begin
		pr = colour_q[3*CH_W-1:2*CH_W];
		pg = colour_q[2*CH_W-1:CH_W];
		pb = colour_q[CH_W-1:0];
		case (pattern)
			PAT_GRID: begin
				if (black) begin
					pr = '0; pg = '0; pb = '0;
				end
			end
			PAT_SUBPIX: begin
				if (black) begin
					pr = '0; pg = '0; pb = '0;
				end else if (k_q < geom.s1) begin
					pg = '0; pb = '0;
				end else if (k_q < geom.s2) begin
					pr = '0; pb = '0;
				end else begin
					pr = '0; pg = '0;
				end
			end
			default: begin
				// plain copy, also for the unused pattern code
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			// a new span starts straight after the last pixel of the previous one
			if (cmd_pop) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (advance) begin
				k_q <= k_q + 1'b1;
				if (at_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			colour_q <= cmd.colour;
			row0_q   <= cmd.row0;
		end
		if (advance) begin
			red_q   <= pr;
			green_q <= pg;
			blue_q  <= pb;
			last_q  <= at_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_red     = red_q;
	assign result.out_green   = green_q;
	assign result.out_blue    = blue_q;
	assign result.last_of_run = last_q;

	a_k_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> k_q <= geom.sm1)
		else $error("pixel index ran past the span");
	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		advance && at_last |=> result.valid && result.last_of_run)
		else $error("final pixel of span not marked");

endmodule
`default_nettype wire

@@ test/tb_pixel_grid_upscaler_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for pixel_grid_upscaler_top: random loads and emits against a span predictor.
module tb_pixel_grid_upscaler_top;
	import pgu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		mode_t              mode;
		logic [COL_W-1:0]   column;
		logic [ROW_W-1:0]   sub_row;
		logic [CH_W-1:0]    red;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    blue;
	} src_item_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	pgu_in_if  src_if();
	pgu_out_if pix_if();

	pixel_grid_upscaler_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (src_if),
		.result    (pix_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	src_item_t items_to_send[$];
	pixel_t    expected_pixels[$];
	src_item_t next_item;

	// shadow of the block's state and registers
	logic [COLOUR_W-1:0]  line_shadow [LINE_PIXELS];
	logic [PAT_W-1:0]     cur_pattern = PAT_SUBPIX;
	logic [STRETCH_W-1:0] cur_stretch = 5'd10;
	logic [LINE_PIXELS-1:0] loaded_cols = '0;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_if.valid   <= 1'b0;
			src_if.mode    <= MODE_LOAD;
			src_if.column  <= '0;
			src_if.sub_row <= '0;
			src_if.red     <= '0;
			src_if.green   <= '0;
			src_if.blue    <= '0;
		end else if (!src_if.valid || src_if.ready) begin
			if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = items_to_send.pop_front();
				src_if.valid   <= 1'b1;
				src_if.mode    <= next_item.mode;
				src_if.column  <= next_item.column;
				src_if.sub_row <= next_item.sub_row;
				src_if.red     <= next_item.red;
				src_if.green   <= next_item.green;
				src_if.blue    <= next_item.blue;
			end else begin
				src_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_if.ready <= 1'b0;
		end else begin
			pix_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void predict_span(input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] row);
		int s;
		int s1;
		int s2;
		int k;
		logic [COLOUR_W-1:0] colour;
		pixel_t px;
		s = int'(cur_stretch);
		if (s < 2) s = 2;
		if (s > STRETCH_MAX) s = STRETCH_MAX;
		s1 = 1 + (s - 1) / 3;
		s2 = 2 * s1 - 1;
		colour = (int'(col) < LINE_PIXELS) ? line_shadow[col] : '0;
		for (k = 0; k < s; k++) begin
			px.red   = colour[3*CH_W-1:2*CH_W];
			px.green = colour[2*CH_W-1:CH_W];
			px.blue  = colour[CH_W-1:0];
			if (cur_pattern == PAT_GRID || cur_pattern == PAT_SUBPIX) begin
				if (row == '0 || k == 0) begin
					px.red   = '0;
					px.green = '0;
					px.blue  = '0;
				end else if (cur_pattern == PAT_SUBPIX) begin
					if (k < s1) begin
						px.green = '0;
						px.blue  = '0;
					end else if (k < s2) begin
						px.red  = '0;
						px.blue = '0;
					end else begin
						px.red   = '0;
						px.green = '0;
					end
				end
			end
			px.last = (k == s - 1);
			expected_pixels.push_back(px);
		end
	endfunction

	// prediction on each accepted item
	always @(posedge clk) begin
		if (arst_n && src_if.valid && src_if.ready) begin
			if (src_if.mode == MODE_LOAD) begin
				if (int'(src_if.column) < LINE_PIXELS)
					line_shadow[src_if.column] <= {src_if.red, src_if.green, src_if.blue};
			end else begin
				predict_span(src_if.column, src_if.sub_row);
			end
		end
	end

	function automatic void check_field(input string name, input logic [CH_W-1:0] want,
			input logic [CH_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : pixel_monitor
		pixel_t want;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel with none expected: %0h %0h %0h last %0b",
					pix_if.out_red, pix_if.out_green, pix_if.out_blue, pix_if.last_of_run);
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("out_red", want.red, pix_if.out_red);
				check_field("out_green", want.green, pix_if.out_green);
				check_field("out_blue", want.blue, pix_if.out_blue);
				check_field("last_of_run", CH_W'(want.last), CH_W'(pix_if.last_of_run));
			end
		end
	end

	task automatic enqueue_item(input mode_t m, input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] row, input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		src_item_t it;
		it.mode    = m;
		it.column  = col;
		it.sub_row = row;
		it.red     = r;
		it.green   = g;
		it.blue    = b;
		if (m == MODE_LOAD) loaded_cols[col] = 1'b1;
		items_to_send.push_back(it);
	endtask

	// mostly emits from loaded columns; a never-loaded column gets a load instead
	task automatic enqueue_random();
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		col = COL_W'($urandom_range(LINE_PIXELS - 1));
		row = ($urandom_range(4) == 0) ? '0 : ROW_W'($urandom);
		if ($urandom_range(99) < 30 || !loaded_cols[col])
			enqueue_item(MODE_LOAD, col, row, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
		else
			enqueue_item(MODE_EMIT, col, row, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
	endtask

	// loads give no pixels, so allow the pipe to empty after the last one
	task automatic wait_drained();
		do @(negedge clk);
		while (items_to_send.size() != 0 || src_if.valid || expected_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_config(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PATTERN)
			cur_pattern = value[PAT_W-1:0];
		else
			cur_stretch = value[STRETCH_W-1:0];
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] pat, input logic [CFG_W-1:0] str,
			input int unsigned idle, input int unsigned stall, input int count,
			input bit pause_mid);
		int n;
		write_config(CFG_PATTERN, pat);
		write_config(CFG_STRETCH, str);
		@(negedge clk);
		send_idle_pct = idle;
		stall_pct     = stall;
		for (n = 0; n < count; n++) begin
			if (pause_mid && n == count / 2) wait_drained();
			enqueue_random();
		end
		wait_drained();
	endtask

	initial begin : stimulus
		int n;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_PATTERN;
		cfg_data       = '0;
		src_if.valid   = 1'b0;
		src_if.mode    = MODE_LOAD;
		src_if.column  = '0;
		src_if.sub_row = '0;
		src_if.red     = '0;
		src_if.green   = '0;
		src_if.blue    = '0;
		pix_if.ready   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items at reset settings: subpixel stripes, stretch ten
		enqueue_item(MODE_LOAD, 5'd0,  4'd15, 8'hff, 8'hff, 8'hff);
		enqueue_item(MODE_LOAD, 5'd31, 4'd0,  8'h00, 8'h00, 8'h00);
		enqueue_item(MODE_LOAD, 5'd1,  4'd3,  8'hff, 8'h00, 8'h00);
		enqueue_item(MODE_LOAD, 5'd2,  4'd5,  8'h00, 8'hff, 8'h00);
		enqueue_item(MODE_LOAD, 5'd3,  4'd9,  8'h00, 8'h00, 8'hff);
		enqueue_item(MODE_LOAD, 5'd30, 4'd1,  8'ha5, 8'h5a, 8'hc3);
		enqueue_item(MODE_EMIT, 5'd0,  4'd0,  8'h00, 8'h00, 8'h00);
		enqueue_item(MODE_EMIT, 5'd0,  4'd1,  8'h00, 8'h00, 8'h00);
		enqueue_item(MODE_EMIT, 5'd31, 4'd15, 8'hff, 8'hff, 8'hff);
		enqueue_item(MODE_EMIT, 5'd1,  4'd9,  8'h00, 8'h00, 8'h00);
		// row beyond the band counts as an interior row
		enqueue_item(MODE_EMIT, 5'd2,  4'd12, 8'h00, 8'h00, 8'h00);
		enqueue_item(MODE_EMIT, 5'd3,  4'd2,  8'h00, 8'h00, 8'h00);
		// reload then read the same column straight away
		enqueue_item(MODE_LOAD, 5'd0,  4'd0,  8'h12, 8'h34, 8'h56);
		enqueue_item(MODE_EMIT, 5'd0,  4'd4,  8'h00, 8'h00, 8'h00);
		enqueue_item(MODE_EMIT, 5'd30, 4'd7,  8'hff, 8'hff, 8'hff);
		enqueue_item(MODE_EMIT, 5'd30, 4'd0,  8'h00, 8'h00, 8'h00);
		for (n = 0; n < 20; n++) enqueue_random();
		wait_drained();

		run_phase(5'd0, 5'd2,  0,  0,  50, 1'b0);
		run_phase(5'd1, 5'd16, 56, 0,  50, 1'b0);
		run_phase(5'd2, 5'd16, 0,  56, 50, 1'b1);
		run_phase(5'd2, 5'd2,  29, 29, 50, 1'b0);
		// unused pattern code and stretch values outside the legal range
		run_phase(5'd3, 5'd31, 56, 0,  50, 1'b0);
		run_phase(5'd2, 5'd0,  0,  56, 50, 1'b0);
		run_phase(5'd1, 5'd5,  29, 29, 50, 1'b0);
		run_phase(5'd2, 5'd4,  0,  0,  50, 1'b0);
		run_phase(5'd2, 5'd1,  29, 29, 40, 1'b0);

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
